FILE: src/assert_macros.svh
// Assertion macros used by the predictor controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define HAP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

FILE: src/hap_pkg.sv
// Types and constants of the hyperspectral adaptive predictor
package hap_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_PRED,
    ST_DIV,
    ST_MAP,
    ST_UPD,
    ST_OUT
  } state_e;

  localparam logic [1:0] REG_MAX_ERROR = 2'd0;
  localparam logic [1:0] REG_RATE_MIN  = 2'd1;
  localparam logic [1:0] REG_RATE_MAX  = 2'd2;
  localparam logic [1:0] REG_RATE_INTV = 2'd3;

  localparam int DIFF_W = 19;
  localparam int DIV_STEPS = 18;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic dot_step;
    logic pred;
    logic div_start;
    logic div_step;
    logic map;
    logic upd_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dot_last;
    logic div_last;
    logic upd_last;
  } stat_t;

endpackage

FILE: src/hap_ctrl.sv
// Controller state machine of the predictor
`include "assert_macros.svh"
module hap_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hap_pkg::cmd_t   cmd_o,
  input  hap_pkg::stat_t  stat_i
);
  hap_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hap_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      hap_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = hap_pkg::ST_DOT;
        end
      end
      hap_pkg::ST_DOT: begin
        cmd_o.dot_step = 1'b1;
        if (stat_i.dot_last) state_d = hap_pkg::ST_PRED;
      end
      hap_pkg::ST_PRED: begin
        cmd_o.pred = 1'b1;
        state_d = hap_pkg::ST_DIV;
      end
      hap_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = hap_pkg::ST_MAP;
      end
      hap_pkg::ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d = hap_pkg::ST_UPD;
      end
      hap_pkg::ST_UPD: begin
        cmd_o.upd_step = 1'b1;
        if (stat_i.upd_last) begin
          cmd_o.commit = 1'b1;
          state_d = hap_pkg::ST_OUT;
        end
      end
      hap_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        // take the next item as the result leaves
        in_ready_o = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d = hap_pkg::ST_DOT;
          end else begin
            state_d = hap_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = hap_pkg::ST_IDLE;
    endcase
    cmd_o.div_start = cmd_o.pred;
  end

  `HAP_ASSERT(a_out_only_in_out, clk_i, rst_ni, out_valid_o |-> state_q == hap_pkg::ST_OUT, "result shown outside output state")
  `HAP_ASSERT(a_load_when_ready, clk_i, rst_ni, cmd_o.load |-> in_ready_o && in_valid_i, "load without handshake")
  `HAP_ASSERT(a_pred_after_dot, clk_i, rst_ni, state_q == hap_pkg::ST_PRED |-> $past(state_q) == hap_pkg::ST_DOT, "prediction not after dot product")
endmodule

FILE: src/hap_datapath.sv
// Datapath of the predictor: dot product, quantiser, mapper, weight update
module hap_datapath #(
  parameter int HISTORY_BANDS = 3,
  parameter int WEIGHT_RES    = 13,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hap_pkg::cmd_t       cmd_i,
  output hap_pkg::stat_t      stat_o,
  input  logic [15:0]         sample_value_i,
  input  logic [15:0]         neighbor_value_i,
  input  logic [23:0]         pixel_index_i,
  input  logic [15:0]         band_index_i,
  input  logic                load_default_weights_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output logic [15:0]         mapped_index_o
);
  localparam int WW  = WEIGHT_RES + 3;
  localparam int DW  = hap_pkg::DIFF_W;
  localparam int PW  = DW + WW;
  localparam int AW  = PW + 6;
  localparam int HW  = SAMPLE_BITS + WEIGHT_RES + 5;
  localparam int IW  = (HISTORY_BANDS > 1) ? $clog2(HISTORY_BANDS) : 1;
  localparam int CW  = $clog2(HISTORY_BANDS + 1);
  localparam int RW  = 18;
  localparam int XW  = DW + 16;
  localparam logic signed [WW-1:0] WMAX = WW'((1 << (WEIGHT_RES + 2)) - 1);
  localparam logic signed [WW-1:0] WMIN = WW'(-(1 << (WEIGHT_RES + 2)));
  localparam longint SMAX = (64'd1 << SAMPLE_BITS) - 1;
  localparam longint SMID = 64'd1 << (SAMPLE_BITS - 1);
  localparam longint HOFS = SMID * (64'd1 << (WEIGHT_RES + 2)) + (64'd1 << (WEIGHT_RES + 1))
                           - 4 * SMID * (64'd1 << WEIGHT_RES);
  localparam longint HMAX = SMAX * (64'd1 << (WEIGHT_RES + 2)) + (64'd1 << (WEIGHT_RES + 1));

  // configuration
  logic [14:0] max_error_q;
  logic signed [4:0] rate_min_q, rate_max_q;
  logic [3:0] rate_intv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_error_q <= '0;
      rate_min_q  <= -5'sd1;
      rate_max_q  <= 5'sd3;
      rate_intv_q <= 4'd6;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hap_pkg::REG_MAX_ERROR: max_error_q <= cfg_data_i[14:0];
        hap_pkg::REG_RATE_MIN:  rate_min_q  <= cfg_data_i[4:0];
        hap_pkg::REG_RATE_MAX:  rate_max_q  <= cfg_data_i[4:0];
        hap_pkg::REG_RATE_INTV: rate_intv_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // state
  logic signed [DW-1:0] hist_q [HISTORY_BANDS];
  logic signed [WW-1:0] w_q [HISTORY_BANDS];
  logic [SAMPLE_BITS-1:0] last_q;

  // item registers
  logic [SAMPLE_BITS-1:0] s_q, nb_q;
  logic [23:0] t_q;
  logic [15:0] z_q;
  logic [CW-1:0] n_q;
  logic [IW-1:0] idx_q;
  logic signed [AW-1:0] acc_q;
  logic [SAMPLE_BITS:0] dres_q;
  logic [RW-1:0] rem_q, quo_q, dvd_q;
  logic [4:0] cnt_q;
  logic rneg_q;
  logic eneg_q;
  logic signed [6:0] p_q;
  logic [15:0] map_q;

  logic [CW-1:0] n_d;
  always_comb begin
    if (band_index_i < 16'(HISTORY_BANDS)) n_d = CW'(band_index_i);
    else n_d = CW'(HISTORY_BANDS);
  end

  logic signed [PW-1:0] prod;
  assign prod = hist_q[idx_q] * w_q[idx_q];
  logic idx_last;
  assign idx_last = (32'(idx_q) == HISTORY_BANDS - 1);
  assign stat_o.dot_last = idx_last;
  assign stat_o.upd_last = idx_last;
  assign stat_o.div_last = (cnt_q == 5'(hap_pkg::DIV_STEPS - 1));

  // prediction from the accumulator
  logic signed [HW+1:0] high;
  logic [SAMPLE_BITS:0] dres_d;
  always_comb begin
    high = (HW+2)'(acc_q) + (HW+2)'(signed'({2'b0, nb_q, 2'b0}) <<< WEIGHT_RES)
         + (HW+2)'(HOFS);
    if (high > (HW+2)'(HMAX)) high = (HW+2)'(HMAX);
    if (high < 0) high = '0;
    if (t_q != '0) dres_d = (SAMPLE_BITS+1)'(high >>> (WEIGHT_RES + 1));
    else if (z_q != '0) dres_d = {last_q, 1'b0};
    else dres_d = (SAMPLE_BITS+1)'(2 * SMID);
  end
  logic [SAMPLE_BITS-1:0] pred;
  assign pred = dres_q[SAMPLE_BITS:1];
  logic signed [SAMPLE_BITS+1:0] r;
  assign r = signed'({2'b0, s_q}) - signed'({2'b0, dres_d[SAMPLE_BITS:1]});

  // restoring divide of |r|+m by 2m+1, one bit a step; for the first pixel the quotient is |r| itself
  logic [RW-1:0] dvs;
  assign dvs = RW'({max_error_q, 1'b1});
  logic [RW:0] trial;
  assign trial = {rem_q, dvd_q[RW-1]} - {1'b0, dvs};

  // mapper
  logic [SAMPLE_BITS:0] theta, aq;
  logic signed [SAMPLE_BITS+1:0] q, sq;
  logic [SAMPLE_BITS+1:0] mapped;
  always_comb begin
    theta = (pred < SAMPLE_BITS'(SMAX) - pred) ? {1'b0, pred}
          : {1'b0, SAMPLE_BITS'(SMAX) - pred};
    aq = (SAMPLE_BITS+1)'(quo_q);
    q = rneg_q ? -signed'({1'b0, aq}) : signed'({1'b0, aq});
    sq = dres_q[0] ? -q : q;
    if (aq > theta) mapped = (SAMPLE_BITS+2)'(aq) + (SAMPLE_BITS+2)'(theta);
    else if (sq >= 0 && sq <= signed'({1'b0, theta})) mapped = {aq, 1'b0};
    else mapped = {aq, 1'b0} - 1'b1;
  end

  // update exponent
  logic signed [25:0] tm5, tsh;
  logic signed [26:0] pe;
  logic signed [6:0] p_d;
  always_comb begin
    tm5 = signed'({2'b0, t_q}) - 26'sd5;
    tsh = tm5 >>> rate_intv_q;
    pe = 27'(rate_min_q) + 27'(tsh);
    if (pe > 27'(rate_max_q)) p_d = 7'(rate_max_q);
    else if (pe < 27'(rate_min_q)) p_d = 7'(rate_min_q);
    else p_d = 7'(pe);
    p_d = p_d + 7'(SAMPLE_BITS - WEIGHT_RES);
  end

  // weight increment of the selected entry
  logic signed [XW-1:0] x, inc;
  logic signed [XW:0] wn;
  logic signed [WW-1:0] wc;
  always_comb begin
    x = eneg_q ? -XW'(hist_q[idx_q]) : XW'(hist_q[idx_q]);
    if (p_q <= 0) inc = ((x <<< (-p_q)) + 1) >>> 1;
    else inc = (x + (XW'(1) <<< p_q)) >>> (p_q + 1);
    // sum at full width, then clip to the weight range
    wn = (XW+1)'(w_q[idx_q]) + (XW+1)'(inc);
    if (wn > (XW+1)'(WMAX)) wc = WMAX;
    else if (wn < (XW+1)'(WMIN)) wc = WMIN;
    else wc = WW'(wn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_BANDS; i++) begin
        hist_q[i] <= '0;
        w_q[i] <= '0;
      end
      last_q <= '0;
    end else begin
      if (cmd_i.load && load_default_weights_i) begin
        for (int i = 0; i < HISTORY_BANDS; i++)
          w_q[i] <= WW'(((7 << WEIGHT_RES) >> 3) >> (3 * i));
      end
      if (cmd_i.upd_step && t_q != '0) w_q[idx_q] <= wc;
      if (cmd_i.commit) begin
        for (int i = HISTORY_BANDS - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
        hist_q[0] <= signed'({1'b0, s_q, 2'b0}) - signed'({1'b0, nb_q, 2'b0});
        last_q <= s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= sample_value_i[SAMPLE_BITS-1:0];
      nb_q <= neighbor_value_i[SAMPLE_BITS-1:0];
      t_q <= pixel_index_i;
      z_q <= band_index_i;
      n_q <= n_d;
      idx_q <= '0;
      acc_q <= '0;
    end
    if (cmd_i.dot_step) begin
      if (32'(idx_q) < 32'(n_q)) acc_q <= acc_q + AW'(prod);
      idx_q <= idx_last ? '0 : idx_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      dres_q <= dres_d;
      rneg_q <= r < 0;
      eneg_q <= (signed'({2'b0, s_q, 1'b0}) - signed'({2'b0, dres_d})) < 0;
      p_q <= p_d;
      rem_q <= '0;
      cnt_q <= '0;
      if (t_q == '0) begin
        dvd_q <= RW'(r < 0 ? -r : r) << 0;
      end else begin
        dvd_q <= RW'(r < 0 ? -r : r) + RW'(max_error_q);
      end
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
      dvd_q <= dvd_q << 1;
      if (t_q == '0) begin
        quo_q <= (cnt_q == '0) ? dvd_q : quo_q;
      end else if (!trial[RW]) begin
        rem_q <= trial[RW-1:0];
        quo_q <= {quo_q[RW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[RW-2:0], dvd_q[RW-1]};
        quo_q <= {quo_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.map) map_q <= mapped[15:0];
    if (cmd_i.upd_step) idx_q <= idx_last ? '0 : idx_q + 1'b1;
  end

  assign mapped_index_o = map_q;
endmodule

FILE: src/hyperspectral_adaptive_predictor.sv
// Top level of the hyperspectral adaptive predictor
// The next item is taken as the result leaves.
// The work is done by the serial dot product, the 18-step restoring quantiser divider
// and the serial weight update, the first and last taking one history entry a cycle.
// Reset clears history, weights and last sample and sets the configuration registers
// to their defaults at once.
module hyperspectral_adaptive_predictor #(
  parameter int HISTORY_BANDS = 3,
  parameter int WEIGHT_RES    = 13,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_value_i,
  input  logic [15:0] neighbor_value_i,
  input  logic [23:0] pixel_index_i,
  input  logic [15:0] band_index_i,
  input  logic        load_default_weights_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mapped_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  hap_pkg::cmd_t cmd;
  hap_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  hap_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  hap_datapath #(
    .HISTORY_BANDS(HISTORY_BANDS), .WEIGHT_RES(WEIGHT_RES), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .sample_value_i, .neighbor_value_i, .pixel_index_i, .band_index_i,
    .load_default_weights_i, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .mapped_index_o
  );
endmodule
